// ===== sv/moving_average_skip_invalid_assert.svh =====
// Assertion macros for the moving average block.
`ifndef MOVING_AVERAGE_SKIP_INVALID_ASSERT_SVH
`define MOVING_AVERAGE_SKIP_INVALID_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define MAS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define MAS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/mas_pkg.sv =====
// Package for the moving average block: widths, reset marker and chain types.
`timescale 1ns / 1ps
package mas_pkg;

  localparam int unsigned DATA_W       = 11;
  localparam int unsigned WINDOW_MAX   = 64;
  localparam int unsigned WINDOW_LEN_D = 10;
  localparam int unsigned CNT_W        = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SUM_W        = DATA_W + $clog2(WINDOW_MAX);
  localparam int unsigned OCNT_W       = 4;
  localparam logic [DATA_W-1:0] MARKER_RESET = DATA_W'(2000);
  localparam logic [OCNT_W-1:0] OCNT_MAX     = '1;

  // partial sum travelling down the cell chain
  typedef struct packed {
    logic             vld;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } part_t;

endpackage

// ===== sv/mas_cell.sv =====
// One window slot: holds an entry and adds it to the passing partial sum when it differs from the marker.
`timescale 1ns / 1ps
module mas_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       shift_i,
  input  logic                       fill_i,
  input  logic [mas_pkg::DATA_W-1:0] marker_i,
  input  logic [mas_pkg::DATA_W-1:0] entry_i,
  output logic [mas_pkg::DATA_W-1:0] entry_o,
  input  mas_pkg::part_t             part_i,
  output mas_pkg::part_t             part_o
);

  logic [mas_pkg::DATA_W-1:0] entry_q;
  logic                       vld_q;
  logic [mas_pkg::SUM_W-1:0]  sum_q, sum_d;
  logic [mas_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                       hit;

  assign hit   = (entry_q != marker_i);
  assign sum_d = part_i.sum + (hit ? mas_pkg::SUM_W'(entry_q) : '0);
  assign cnt_d = part_i.cnt + (hit ? mas_pkg::CNT_W'(1) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= mas_pkg::MARKER_RESET;
      vld_q   <= 1'b0;
    end else begin
      vld_q <= part_i.vld;
      if (fill_i) begin
        entry_q <= marker_i;
      end else if (shift_i) begin
        entry_q <= entry_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    cnt_q <= cnt_d;
  end

  assign entry_o    = entry_q;
  assign part_o.vld = vld_q;
  assign part_o.sum = sum_q;
  assign part_o.cnt = cnt_q;

endmodule

// ===== sv/mas_div.sv =====
// Restoring divider, one quotient bit per cycle, for window sum over count.
`timescale 1ns / 1ps
module mas_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mas_pkg::SUM_W-1:0] dividend_i,
  input  logic [mas_pkg::CNT_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [mas_pkg::SUM_W-1:0] quot_o
);

  localparam int unsigned STEP_W = $clog2(mas_pkg::SUM_W);

  logic [mas_pkg::CNT_W-1:0] rem_q, rem_d, dsr_q;
  logic [mas_pkg::SUM_W-1:0] quo_q, quo_d;
  logic [STEP_W-1:0]         step_q;
  logic                      busy_q, done_q;
  logic [mas_pkg::CNT_W:0]   trial, diff;
  logic                      ge;

  assign trial = {rem_q, quo_q[mas_pkg::SUM_W-1]};
  assign ge    = (trial >= {1'b0, dsr_q});
  assign diff  = trial - {1'b0, dsr_q};
  assign rem_d = ge ? diff[mas_pkg::CNT_W-1:0] : trial[mas_pkg::CNT_W-1:0];
  assign quo_d = {quo_q[mas_pkg::SUM_W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(mas_pkg::SUM_W - 1);
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== sv/moving_average_skip_invalid.sv =====
// Top level of the moving average block: cell chain, divider and handshake.
//
// Requests arrive on in_valid_i/in_ready_o with func_i and sample_i.
// func_i low shifts sample_i into the window (oldest entry drops out);
// func_i high refills every slot with the invalid marker.
// Each request yields one result on out_valid_o/out_ready_i: the truncated
// mean of the entries that differ from the marker, their count (saturating
// at 15) and a flag when none are valid, in which case the mean is the marker.
// The marker is written through cfg_we_i/cfg_wdata_i; reset sets it to 2000
// and fills the window with it.
// Steps: the window is updated in a register, the partial sum walks the cell
// chain, the bit-serial divider works out SUM_W (17) quotient bits, the
// result is handed over and the output register is loaded. One request is
// in flight at a time, so a new request is taken only once the previous
// one has left the divider for the output register.
// A finished result sits in the output register while the next request is
// taken; if the receiver still stalls when that one finishes, it waits in
// the divider and no further request is taken.
`timescale 1ns / 1ps
`include "moving_average_skip_invalid_assert.svh"
module moving_average_skip_invalid #(
  parameter int unsigned WINDOW_LEN = mas_pkg::WINDOW_LEN_D
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        func_i,
  input  logic [mas_pkg::DATA_W-1:0]  sample_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mas_pkg::DATA_W-1:0]  average_o,
  output logic [mas_pkg::OCNT_W-1:0]  valid_count_o,
  output logic                        none_valid_o,
  input  logic                        cfg_we_i,
  input  logic [mas_pkg::DATA_W-1:0]  cfg_wdata_i
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_HOLD} state_e;

  state_e                      state_q;
  logic                        accept, shift, fill, start_q;
  logic [mas_pkg::DATA_W-1:0]  marker_q;
  logic [mas_pkg::DATA_W-1:0]  entry [WINDOW_LEN];
  mas_pkg::part_t              part  [WINDOW_LEN];
  mas_pkg::part_t              part_head;
  logic [mas_pkg::CNT_W-1:0]   cnt_q;
  logic                        div_busy, div_done;
  logic [mas_pkg::SUM_W-1:0]   div_quot;
  logic                        out_valid_q, none_valid_q;
  logic [mas_pkg::DATA_W-1:0]  average_q;
  logic [mas_pkg::OCNT_W-1:0]  valid_count_q;
  logic                        slot_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign shift      = accept && !func_i;
  assign fill       = accept && func_i;
  assign slot_free  = !out_valid_q || out_ready_i;

  assign part_head.vld = start_q;
  assign part_head.sum = '0;
  assign part_head.cnt = '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= mas_pkg::MARKER_RESET;
      start_q  <= 1'b0;
    end else begin
      start_q <= accept;
      if (cfg_we_i) begin
        marker_q <= cfg_wdata_i;
      end
    end
  end

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    logic [mas_pkg::DATA_W-1:0] nb_entry;
    mas_pkg::part_t             nb_part;
    if (i == WINDOW_LEN - 1) begin : g_newest
      assign nb_entry = sample_i;
    end else begin : g_mid
      assign nb_entry = entry[i+1];
    end
    if (i == 0) begin : g_oldest
      assign nb_part = part_head;
    end else begin : g_tail
      assign nb_part = part[i-1];
    end
    mas_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift),
      .fill_i   (fill),
      .marker_i (marker_q),
      .entry_i  (nb_entry),
      .entry_o  (entry[i]),
      .part_i   (nb_part),
      .part_o   (part[i])
    );
  end

  mas_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (part[WINDOW_LEN-1].vld),
    .dividend_i (part[WINDOW_LEN-1].sum),
    .divisor_i  (part[WINDOW_LEN-1].cnt),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
      average_q     <= '0;
      valid_count_q <= '0;
      none_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_HOLD) begin
        out_valid_q <= 1'b0;
      end
      if (part[WINDOW_LEN-1].vld) begin
        cnt_q <= part[WINDOW_LEN-1].cnt;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          if (div_done) begin
            state_q <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (slot_free) begin
            out_valid_q   <= 1'b1;
            none_valid_q  <= (cnt_q == '0);
            average_q     <= (cnt_q == '0) ? marker_q : div_quot[mas_pkg::DATA_W-1:0];
            valid_count_q <= (cnt_q > mas_pkg::CNT_W'(mas_pkg::OCNT_MAX)) ?
                             mas_pkg::OCNT_MAX : cnt_q[mas_pkg::OCNT_W-1:0];
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign average_o     = average_q;
  assign valid_count_o = valid_count_q;
  assign none_valid_o  = none_valid_q;

  `MAS_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, accept, !in_ready_o)
  `MAS_ASSERT_IMPL(a_chain_to_idle_div, clk_i, rst_ni, part[WINDOW_LEN-1].vld, state_q == S_RUN && !div_busy)
  `MAS_ASSERT_IMPL(a_empty_result, clk_i, rst_ni, out_valid_o && none_valid_o, valid_count_o == '0 && average_o == marker_q)

endmodule
